>>> sv/smpq_pkg.sv
// Shared types and codes for the sorted max-priority queue.
// No dependencies; imported by sorted_max_priority_queue_top.
`default_nettype none

package smpq_pkg;

    // Operation selector carried on the input tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Result status carried on the output tuser
    localparam int unsigned STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,     // waiting for an item
        ST_INS_CMP,  // walking down the list, shifting larger entries up
        ST_INS_WR,   // new value goes to slot 0
        ST_REM_RD,   // head read returning from memory
        ST_FINISH    // result waits for the output register
    } t_state;

endpackage

`default_nettype wire

>>> sv/sorted_max_priority_queue_top.sv
// Bounded max-priority queue kept sorted in one synchronous RAM.
// Depends on smpq_pkg (codes, state type).
//
//  channel  | dir | tdata (low bit up)                     | tuser
//  ---------+-----+----------------------------------------+-------------------
//  s_axis   | in  | value                                  | func (0 ins, 1 rem)
//  m_axis   | out | removed_value, occupancy               | status
//
// Entries are held in ascending slot order, largest at slot count-1, so a
// remove is one RAM read. An insert walks from the top slot down, one RAM
// read and one shifting write a cycle, past every entry larger than the
// value; a full or empty case skips the walk. One item is in flight at a
// time; the output register lets the next item be accepted while a result
// still waits on m_axis_tready.
// Reset clears the count and the handshake state; the RAM is not cleared.
`default_nettype none

module sorted_max_priority_queue_top
    import smpq_pkg::*;
#(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // [VALUE_BITS-1:0] value, rest zero
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [0] func
    input  wire logic s_axis_tuser,

    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // [VALUE_BITS-1:0] removed_value, then occupancy, rest zero
    output logic [((VALUE_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
    // [1:0] status
    output logic [STATUS_BITS-1:0] m_axis_tuser
);

    localparam int unsigned AW     = $clog2(CAPACITY);
    localparam int unsigned CW     = $clog2(CAPACITY + 1);
    localparam int unsigned OUT_W  = ((VALUE_BITS + CW + 7) / 8) * 8;
    localparam int unsigned PAD_W  = OUT_W - VALUE_BITS - CW;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    // Storage
    logic [VALUE_BITS-1:0] r_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_rdata;

    // Sequencer and datapath registers
    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_idx,   n_idx;
    logic signed [VALUE_BITS-1:0] r_value, n_value;
    logic [STATUS_BITS-1:0]  r_status, n_status;
    logic [VALUE_BITS-1:0]   r_rem,    n_rem;

    // Output register
    logic                    r_m_valid;
    logic [STATUS_BITS-1:0]  r_m_status;
    logic [VALUE_BITS-1:0]   r_m_value;
    logic [CW-1:0]           r_m_occ;

    // RAM controls
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [VALUE_BITS-1:0]   mem_wdata;
    logic [AW-1:0]           mem_raddr;

    logic                    in_acc;
    logic                    out_free;
    logic                    rd_greater;
    logic [CW-1:0]           count_m1;
    logic signed [VALUE_BITS-1:0] in_value;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign out_free   = !r_m_valid || m_axis_tready;
    assign in_value   = s_axis_tdata[VALUE_BITS-1:0];
    assign count_m1   = r_count - 1'b1;
    assign rd_greater = $signed(r_rdata) > r_value;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == FUNC_REMOVE) begin
                        n_state = (r_count == '0) ? ST_FINISH : ST_REM_RD;
                    end else if (r_count == FULL_COUNT || r_count == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_INS_CMP;
                    end
                end
            end
            ST_INS_CMP: begin
                if (!rd_greater) begin
                    n_state = ST_FINISH;
                end else if (r_idx == '0) begin
                    n_state = ST_INS_WR;
                end
            end
            ST_INS_WR: n_state = ST_FINISH;
            ST_REM_RD: n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Handshake and RAM controls
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_idx + 1'b1;
        mem_wdata     = r_rdata;
        mem_raddr     = count_m1[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                // first insert into an empty list lands in slot 0 at once
                if (in_acc && s_axis_tuser == FUNC_INSERT && r_count == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = in_value;
                end
            end
            ST_INS_CMP: begin
                mem_we    = 1'b1;
                mem_raddr = r_idx - 1'b1;
                // shift the larger entry up, or drop the new value above it
                mem_wdata = rd_greater ? r_rdata : r_value;
            end
            ST_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_value;
            end
            ST_REM_RD: ;
            ST_FINISH: ;
            default:   ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_count  = r_count;
        n_idx    = r_idx;
        n_value  = r_value;
        n_status = r_status;
        n_rem    = r_rem;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_value  = in_value;
                    n_idx    = count_m1[AW-1:0];
                    n_status = STATUS_OK;
                    n_rem    = '0;
                    if (s_axis_tuser == FUNC_REMOVE) begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                        end
                    end else if (r_count == FULL_COUNT) begin
                        n_status = STATUS_FULL;
                    end else if (r_count == '0) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_INS_CMP: begin
                n_idx = r_idx - 1'b1;
                if (!rd_greater) begin
                    n_count = r_count + 1'b1;
                end
            end
            ST_INS_WR: n_count = r_count + 1'b1;
            ST_REM_RD: begin
                n_rem   = r_rdata;
                n_count = count_m1;
            end
            ST_FINISH: ;
            default:   ;
        endcase
    end

    // RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_FINISH && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_status <= n_status;
        r_rem    <= n_rem;
        if (r_state == ST_FINISH && out_free) begin
            r_m_status <= r_status;
            r_m_value  <= r_rem;
            r_m_occ    <= r_count;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_m_occ, r_m_value};

endmodule

`default_nettype wire
